/* hdl/ftok_pkg.sv */
// Shared types and constants for the formula tokenizer.
// Used by ftok_front, ftok_fifo, ftok_back and formula_tokenizer_unit.
`default_nettype none

package ftok_pkg;

    // Most results one character can cause: pending dot + ".." concat
    localparam int MAX_RES     = 6;
    localparam int COUNT_W     = 3;
    localparam int FIFO_DEPTH  = 4;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_END     = 2'd1,
        KIND_FORMULA = 2'd2
    } kind_t;

    typedef enum logic {
        OP_CHAR  = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] tbyte;
    } res_t;

    // One queued burst: the results caused by one input, slot 0 first
    typedef struct packed {
        logic [COUNT_W-1:0]       count;
        res_t [MAX_RES-1:0]       res;
    } burst_t;

endpackage

`default_nettype wire

/* hdl/ftok_front.sv */
// Front end: lexer state and classification of each input character into a burst.
// Depends on ftok_pkg.
`default_nettype none

module ftok_front
    import ftok_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       operation,
    input  wire logic [7:0] character,
    input  wire logic       fifo_full,
    output logic            push,
    output burst_t          burst
);

    typedef struct packed {
        logic quote_open;
        logic dot_pending;
        logic escape_pending;
        logic comment_reached;
        logic nonempty;
        logic all_digits;
        logic lone_star;
        logic operand_pos;
    } tok_state_t;

    typedef struct packed {
        tok_state_t st;
        burst_t     bu;
    } step_t;

    localparam tok_state_t STATE_RESET = '{
        quote_open: 1'b0, dot_pending: 1'b0, escape_pending: 1'b0,
        comment_reached: 1'b0, nonempty: 1'b0, all_digits: 1'b1,
        lone_star: 1'b0, operand_pos: 1'b1
    };

    tok_state_t state_reg;
    tok_state_t state_next;
    step_t      step;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic step_t f_emit(input step_t s, input kind_t k, input logic [7:0] b);
        step_t r;
        r = s;
        if (r.bu.count < COUNT_W'(MAX_RES))
        begin
            r.bu.res[r.bu.count].kind  = k;
            r.bu.res[r.bu.count].tbyte = b;
            r.bu.count = r.bu.count + COUNT_W'(1);
        end
        return r;
    endfunction

    function automatic step_t f_append(input step_t s, input logic [7:0] b);
        step_t r;
        r = f_emit(s, KIND_BYTE, b);
        if (!r.st.nonempty)
        begin
            r.st.all_digits = is_digit(b);
            r.st.lone_star  = (b == CH_STAR);
        end
        else
        begin
            r.st.all_digits = r.st.all_digits & is_digit(b);
            r.st.lone_star  = 1'b0;
        end
        r.st.nonempty = 1'b1;
        return r;
    endfunction

    function automatic step_t f_end(input step_t s);
        step_t r;
        r = s;
        if (r.st.nonempty)
        begin
            r = f_emit(r, KIND_END, 8'h00);
            r.st.operand_pos = r.st.lone_star;
        end
        r.st.nonempty   = 1'b0;
        r.st.all_digits = 1'b1;
        r.st.lone_star  = 1'b0;
        return r;
    endfunction

    function automatic step_t f_symbol(input step_t s, input logic [7:0] c,
                                       input logic operand_after);
        step_t r;
        r = f_end(s);
        r = f_emit(r, KIND_BYTE, c);
        r = f_emit(r, KIND_END, 8'h00);
        r.st.operand_pos = operand_after;
        return r;
    endfunction

    function automatic step_t f_concat(input step_t s);
        step_t r;
        r = f_end(s);
        r = f_emit(r, KIND_BYTE, CH_SPACE);
        r = f_emit(r, KIND_BYTE, CH_DOT);
        r = f_emit(r, KIND_BYTE, CH_DOT);
        r = f_emit(r, KIND_BYTE, CH_SPACE);
        r = f_emit(r, KIND_END, 8'h00);
        r.st.operand_pos = 1'b1;
        return r;
    endfunction

    function automatic step_t f_plain(input step_t s, input logic [7:0] c);
        step_t r;
        r = s;
        case (c) inside
            CH_LPAREN, CH_RPAREN, CH_COMMA:
            begin
                if (r.st.quote_open)
                    r = f_append(r, c);
                else
                    r = f_symbol(r, c, c != CH_RPAREN);
            end
            CH_DOT:
            begin
                if (r.st.quote_open || (r.st.nonempty && r.st.all_digits))
                    r = f_append(r, c);
                else
                    r.st.dot_pending = 1'b1;
            end
            CH_STAR, CH_PLUS, CH_MINUS, CH_SLASH, CH_PCT:
            begin
                if (r.st.quote_open)
                    r = f_append(r, c);
                else if (c == CH_STAR && !r.st.nonempty && r.st.operand_pos)
                    r = f_append(r, c);    // dereference prefix
                else
                    r = f_symbol(r, c, 1'b1);
            end
            CH_SPACE:
            begin
                if (r.st.quote_open)
                    r = f_append(r, c);
                else
                    r = f_end(r);
            end
            CH_QUOTE:
            begin
                r.st.quote_open = !r.st.quote_open;
                r = f_append(r, c);
                if (!r.st.quote_open)
                    r = f_end(r);
            end
            CH_HASH:
            begin
                r.st.comment_reached = 1'b1;
                r = f_end(r);
            end
            CH_BSLASH:
            begin
                if (r.st.quote_open)
                    r.st.escape_pending = 1'b1;
                else
                    r = f_append(r, c);
            end
            default:
                r = f_append(r, c);
        endcase
        return r;
    endfunction

    always_comb
    begin
        step       = '0;
        step.st    = state_reg;
        step.bu    = '0;
        if (operation == OP_FLUSH)
        begin
            if (!state_reg.comment_reached)
            begin
                if (state_reg.dot_pending)
                    step = f_append(step, CH_DOT);
                step = f_end(step);
            end
            step    = f_emit(step, KIND_FORMULA, 8'h00);
            step.st = STATE_RESET;
        end
        else if (state_reg.comment_reached)
        begin
            // rest of the formula is ignored until the flush
        end
        else if (state_reg.escape_pending)
        begin
            step.st.escape_pending = 1'b0;
            if (character == CH_N)
                step = f_append(step, CH_LF);
            else if (character == CH_T)
                step = f_append(step, CH_TAB);
            else
                step = f_append(step, character);
        end
        else if (state_reg.dot_pending)
        begin
            step.st.dot_pending = 1'b0;
            if (character == CH_DOT)
                step = f_concat(step);
            else
            begin
                step = f_append(step, CH_DOT);
                step = f_plain(step, character);
            end
        end
        else
            step = f_plain(step, character);
    end

    assign in_ready   = !fifo_full;
    assign burst      = step.bu;
    assign push       = in_valid && in_ready && (step.bu.count != '0);
    assign state_next = (in_valid && in_ready) ? step.st : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* hdl/ftok_fifo.sv */
// Short burst queue between the lexer front end and the result serializer.
// Depends on ftok_pkg.
`default_nettype none

module ftok_fifo
    import ftok_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire burst_t wdata,
    output logic        full,
    input  wire logic   pop,
    output burst_t      rdata,
    output logic        empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    burst_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic               do_push, do_pop;

    assign full    = (level_reg == LVL_W'(DEPTH));
    assign empty   = (level_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            level_next = level_reg + LVL_W'(1);
        else if (do_pop && !do_push)
            level_next = level_reg - LVL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

/* hdl/ftok_back.sv */
// Back end: walks the queued burst one result per cycle into an output register while out_ready allows.
// Depends on ftok_pkg.
`default_nettype none

module ftok_back
    import ftok_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire burst_t     head,
    input  wire logic       empty,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output kind_t           out_kind,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic               valid_reg, valid_next;
    res_t               res_reg, res_next;
    logic               last_reg, last_next;
    logic               advance;
    logic               at_last;

    assign advance = !valid_reg || out_ready;
    assign at_last = (idx_reg == head.count - COUNT_W'(1));
    assign pop     = advance && !empty && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        res_next   = res_reg;
        last_next  = last_reg;
        if (advance)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                res_next  = head.res[idx_reg];
                last_next = at_last;
                idx_next  = at_last ? '0 : idx_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_kind  = res_reg.kind;
    assign out_byte  = res_reg.tbyte;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

/* hdl/formula_tokenizer_unit.sv */
// Top level of the formula tokenizer: front end, burst queue and result serializer.
// Depends on ftok_pkg, ftok_front, ftok_fifo, ftok_back.
//
//  channel | dir | tdata                | tuser          | tlast
//  s_*     | in  | [7:0] character      | [0] operation  | -
//  m_*     | out | [7:0] token_byte     | [1:0] kind     | last_of_run
//
// One character is taken per cycle while the burst queue has room.
// A character yields zero to six results; the serializer sends one result per cycle while
// m_tready allows, and the front keeps taking characters meanwhile, with FIFO_DEPTH
// bursts of slack between the two sides.
// Reset clears lexer state, queue pointers and the output valid; no clearing pass.
// A stalled m_tready holds the output register; the front keeps going until the queue fills.
`default_nettype none

module formula_tokenizer_unit
    import ftok_pkg::*;
#(
    parameter int FIFO_DEPTH_P = FIFO_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] character
    input  wire logic [0:0] s_tuser,    // [0] operation
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // [7:0] token_byte
    output logic [1:0]      m_tuser,    // [1:0] kind
    output logic            m_tlast
);

    burst_t push_burst;
    burst_t head_burst;
    logic   fifo_push, fifo_full, fifo_pop, fifo_empty;
    kind_t  out_kind;

    ftok_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .operation (s_tuser[0]),
        .character (s_tdata),
        .fifo_full (fifo_full),
        .push      (fifo_push),
        .burst     (push_burst)
    );

    ftok_fifo #(
        .DEPTH (FIFO_DEPTH_P)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fifo_push),
        .wdata (push_burst),
        .full  (fifo_full),
        .pop   (fifo_pop),
        .rdata (head_burst),
        .empty (fifo_empty)
    );

    ftok_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_burst),
        .empty     (fifo_empty),
        .pop       (fifo_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (out_kind),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

    assign m_tuser = out_kind;

    a_formula_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_FORMULA) |-> m_tlast)
        else $error("formula-complete result not last of its run");

    a_mark_has_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_BYTE) |-> (m_tdata == 8'h00))
        else $error("token or formula mark carries a byte");

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> !fifo_empty)
        else $error("serializer popped an empty queue");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> !fifo_full && (push_burst.count != '0))
        else $error("front pushed into a full queue or an empty burst");

endmodule

`default_nettype wire
